/* rtl/cmrl_pkg.sv */
`default_nettype none
package cmrl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SPAN_W      = ADDR_W + 1;

  localparam int IDX_W   = 12;
  localparam int CRATE_W = 8;
  localparam int BOARD_W = 5;
  localparam int CHAN_W  = 5;
  localparam int COUNT_W = 24;
  localparam int ECNT_W  = 13;

  localparam logic [BOARD_W-1:0] BOARD_LIMIT_RESET = BOARD_W'(20);
  localparam logic [CHAN_W-1:0]  CHAN_LIMIT_RESET  = CHAN_W'(16);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ENTRY_COUNT   = 2'd0,
    REG_BOARD_LIMIT   = 2'd1,
    REG_CHANNEL_LIMIT = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_VERIFY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LOOKUP,
    ST_OUTER_RD,
    ST_OUTER_GET,
    ST_INNER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ECNT_W-1:0]  entry_count;
    logic [BOARD_W-1:0] board_limit;
    logic [CHAN_W-1:0]  channel_limit;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [CRATE_W-1:0] crate_number;
    logic [BOARD_W-1:0] board_number;
    logic [CHAN_W-1:0]  channel_number;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   detector_index;
    logic [CRATE_W-1:0] crate_number;
    logic [BOARD_W-1:0] board_number;
    logic [CHAN_W-1:0]  channel_number;
  } item_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [IDX_W-1:0]   match_index;
    logic [COUNT_W-1:0] problem_count;
  } result_t;

endpackage
`default_nettype wire

/* rtl/cmrl_map_ram.sv */
`default_nettype none
module cmrl_map_ram
  import cmrl_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output entry_t        rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/cmrl_cfg.sv */
`default_nettype none
module cmrl_cfg
  import cmrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  reg_idx_t reg_sel;
  logic     wr_en;

  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count   <= '0;
      cfg.board_limit   <= BOARD_LIMIT_RESET;
      cfg.channel_limit <= CHAN_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ENTRY_COUNT:   cfg.entry_count   <= pwdata[ECNT_W-1:0];
        REG_BOARD_LIMIT:   cfg.board_limit   <= pwdata[BOARD_W-1:0];
        REG_CHANNEL_LIMIT: cfg.channel_limit <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENTRY_COUNT:   prdata = APB_DATA_W'(cfg.entry_count);
      REG_BOARD_LIMIT:   prdata = APB_DATA_W'(cfg.board_limit);
      REG_CHANNEL_LIMIT: prdata = APB_DATA_W'(cfg.channel_limit);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/cmrl_seq.sv */
`default_nettype none
module cmrl_seq
  import cmrl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       in_ready,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res,
  output ram_req_t   ram_req,
  input  wire entry_t rd_data
);

  state_t             state, state_next;
  logic [SPAN_W-1:0]  addr, addr_next;
  logic [SPAN_W-1:0]  outer, outer_next;
  logic               pend, pend_next;
  logic [ADDR_W-1:0]  pend_addr, pend_addr_next;
  entry_t             key, key_next;
  logic [COUNT_W-1:0] total, total_next;
  result_t            res_next;
  logic               map_loaded, map_loaded_next;

  logic [SPAN_W-1:0]  span;
  logic               issue;
  logic               hit;
  logic [1:0]         faults;
  logic [COUNT_W:0]   sum;
  logic [1:0]         inc;

  // entry_count above the table depth acts as the depth
  assign span  = (32'(cfg.entry_count) > TABLE_DEPTH) ? SPAN_W'(TABLE_DEPTH)
                                                      : SPAN_W'(cfg.entry_count);
  assign issue = addr < span;
  assign hit   = pend && (rd_data == key);
  assign faults = 2'(rd_data.board_number > cfg.board_limit)
                + 2'(rd_data.channel_number > cfg.channel_limit);
  assign sum   = {1'b0, total} + (COUNT_W+1)'(inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      addr       <= '0;
      pend       <= 1'b0;
      map_loaded <= 1'b0;
    end else begin
      state      <= state_next;
      addr       <= addr_next;
      pend       <= pend_next;
      map_loaded <= map_loaded_next;
    end
  end

  always_ff @(posedge clk) begin
    outer     <= outer_next;
    pend_addr <= pend_addr_next;
    key       <= key_next;
    total     <= total_next;
    res       <= res_next;
  end

  always_comb begin
    state_next      = state;
    addr_next       = addr;
    outer_next      = outer;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    key_next        = key;
    total_next      = total;
    res_next        = res;
    map_loaded_next = map_loaded;
    inc             = 2'd0;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    ram_req         = '0;

    case (state)
      ST_INIT, ST_CLEAR: begin
        // sweep: invalidate one entry a cycle
        ram_req.we    = 1'b1;
        ram_req.waddr = addr[ADDR_W-1:0];
        ram_req.wdata = '0;
        addr_next     = addr + SPAN_W'(1);
        if (addr[ADDR_W-1:0] == ADDR_W'(TABLE_DEPTH - 1)) begin
          addr_next = '0;
          if (state == ST_CLEAR) begin
            map_loaded_next = 1'b1;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_next = '0;
          case (in_item.kind)
            KIND_CLEAR: begin
              addr_next  = '0;
              state_next = ST_CLEAR;
            end
            KIND_WRITE: begin
              ram_req.we    = 32'(in_item.detector_index) < TABLE_DEPTH;
              ram_req.waddr = ADDR_W'(in_item.detector_index);
              ram_req.wdata = '{valid: 1'b1,
                                crate_number: in_item.crate_number,
                                board_number: in_item.board_number,
                                channel_number: in_item.channel_number};
              state_next    = ST_DONE;
            end
            KIND_LOOKUP: begin
              key_next   = '{valid: 1'b1,
                             crate_number: in_item.crate_number,
                             board_number: in_item.board_number,
                             channel_number: in_item.channel_number};
              addr_next  = '0;
              pend_next  = 1'b0;
              state_next = ST_LOOKUP;
            end
            KIND_VERIFY: begin
              if (!map_loaded) begin
                res_next.status = 1'b1;
                state_next      = ST_DONE;
              end else begin
                total_next = '0;
                outer_next = '0;
                state_next = ST_OUTER_RD;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end

      ST_LOOKUP: begin
        // reads issued back to back, compare runs one entry behind
        ram_req.re     = issue;
        ram_req.raddr  = addr[ADDR_W-1:0];
        pend_next      = issue;
        pend_addr_next = addr[ADDR_W-1:0];
        if (issue) begin
          addr_next = addr + SPAN_W'(1);
        end
        if (hit) begin
          res_next.found       = 1'b1;
          res_next.match_index = IDX_W'(pend_addr);
          pend_next            = 1'b0;
          state_next           = ST_DONE;
        end else if (!issue && !pend) begin
          state_next = ST_DONE;
        end
      end

      ST_OUTER_RD: begin
        if (outer >= span) begin
          res_next.problem_count = total;
          state_next             = ST_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = outer[ADDR_W-1:0];
          state_next    = ST_OUTER_GET;
        end
      end

      ST_OUTER_GET: begin
        if (rd_data.valid) begin
          inc        = faults;
          total_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
          key_next   = rd_data;
          addr_next  = outer + SPAN_W'(1);
          pend_next  = 1'b0;
          state_next = ST_INNER;
        end else begin
          outer_next = outer + SPAN_W'(1);
          state_next = ST_OUTER_RD;
        end
      end

      ST_INNER: begin
        // later entries equal to the held one, each is one duplicate pair
        ram_req.re     = issue;
        ram_req.raddr  = addr[ADDR_W-1:0];
        pend_next      = issue;
        pend_addr_next = addr[ADDR_W-1:0];
        if (issue) begin
          addr_next = addr + SPAN_W'(1);
        end
        if (hit) begin
          inc        = 2'd1;
          total_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        end
        if (!issue && !pend) begin
          outer_next = outer + SPAN_W'(1);
          state_next = ST_OUTER_RD;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/channel_map_reverse_lookup.sv */
`default_nettype none
// A write, or a verify before any clear, reads no map entry; a clear sweeps the whole table;
// a lookup reads from entry 0 up to the first match or the span end; a verify reads each entry
// in the span and, for each valid one, every later one; span = min(entry_count, 4096).
// Throughput: one word at a time; lookups and the duplicate scan read the map one entry a cycle.
// Reset: synchronous, active high; a sweep then invalidates all 4096 map entries, with
// s_axis_tready low throughout (configuration writes are taken as normal).
// Registers reset to entry_count 0, board_limit 20, channel_limit 16; map not loaded.
module channel_map_reverse_lookup
  import cmrl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,

  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // detector_index[11:0], crate_number[19:12], board_number[24:20],
  // channel_number[29:25], zero fill [31:30]
  input  wire logic [31:0]           s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]            s_axis_tuser,

  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status[0], found[1], match_index[13:2], problem_count[37:14], zero fill [39:38]
  output logic      [39:0]           m_axis_tdata
);

  cfg_t     cfg;
  item_t    in_item;
  result_t  res;
  logic     res_valid;
  logic     res_ready;
  ram_req_t ram_req;
  entry_t   rd_data;

  cmrl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // unpack the input word
  assign in_item.kind           = kind_t'(s_axis_tuser);
  assign in_item.detector_index = s_axis_tdata[11:0];
  assign in_item.crate_number   = s_axis_tdata[19:12];
  assign in_item.board_number   = s_axis_tdata[24:20];
  assign in_item.channel_number = s_axis_tdata[29:25];

  cmrl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_item   (in_item),
    .in_ready  (s_axis_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

  // map memory: valid, crate, board and channel per detector index
  cmrl_map_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output register: the result word waits here while the sequencer goes on
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {2'b00, res.problem_count, res.match_index, res.found, res.status};
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_channel_map_reverse_lookup.sv */
`default_nettype none
// Self-checking bench for the detector channel map.
// Words go in on the slave stream (kind in tuser, entry fields in tdata) and one result
// word comes back per input word. A behavioural copy of the map sits alongside the
// block: it is updated as each input word is taken and queues the result it predicts.
// A free-running sink pops that queue and compares each result field by field.
module tb_channel_map_reverse_lookup;
  import cmrl_pkg::*;

  // Longest legal silence is a verify over the full table with a few dozen live
  // entries; the limit sits well above that.
  localparam int STALL_LIMIT = 600000;
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;

  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  // detector_index[11:0], crate_number[19:12], board_number[24:20],
  // channel_number[29:25], zero fill [31:30]
  logic [31:0] s_axis_tdata  = '0;
  // kind[1:0]
  logic [1:0]  s_axis_tuser  = '0;

  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[0], found[1], match_index[13:2], problem_count[37:14], zero fill [39:38]
  wire  [39:0] m_axis_tdata;

  channel_map_reverse_lookup uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural map: table contents, live bits, loaded flag and register copies
  // ---------------------------------------------------------------------------
  logic [CRATE_W-1:0] crate_map [TABLE_DEPTH];
  logic [BOARD_W-1:0] board_map [TABLE_DEPTH];
  logic [CHAN_W-1:0]  chan_map  [TABLE_DEPTH];
  bit                 entry_live[TABLE_DEPTH];
  bit                 map_ready = 1'b0;

  logic [ECNT_W-1:0]  span_reg  = '0;
  logic [BOARD_W-1:0] board_lim = BOARD_LIMIT_RESET;
  logic [CHAN_W-1:0]  chan_lim  = CHAN_LIMIT_RESET;

  result_t pending_results[$];
  int      errors = 0;
  // upper bound of the idle draw on both streams; 0 gives back-to-back traffic
  int      pace_max = 18;

  // Applies one word to the map copy and returns the result it should give.
  function automatic result_t map_response(input kind_t k, input logic [IDX_W-1:0] idx,
                                           input logic [CRATE_W-1:0] crate,
                                           input logic [BOARD_W-1:0] board,
                                           input logic [CHAN_W-1:0] chan);
    result_t         res;
    int unsigned     n;
    int unsigned     live[$];
    longint unsigned total;
    res = '0;
    // a count past the table depth only walks the table
    n = (span_reg > TABLE_DEPTH) ? TABLE_DEPTH : span_reg;
    case (k)
      KIND_CLEAR: begin
        foreach (entry_live[i]) entry_live[i] = 1'b0;
        map_ready = 1'b1;
      end
      KIND_WRITE: begin
        // 12-bit index always lands inside the 4096-deep table; loaded flag untouched
        crate_map[idx]  = crate;
        board_map[idx]  = board;
        chan_map[idx]   = chan;
        entry_live[idx] = 1'b1;
      end
      KIND_LOOKUP: begin
        for (int i = 0; i < n; i++) begin
          if (entry_live[i] && crate_map[i] == crate && board_map[i] == board &&
              chan_map[i] == chan) begin
            res.found       = 1'b1;
            res.match_index = IDX_W'(i);
            break;
          end
        end
      end
      default: begin
        if (!map_ready) begin
          res.status = 1'b1;
        end else begin
          total = 0;
          // range faults: an entry may score on board and on channel
          for (int i = 0; i < n; i++) begin
            if (entry_live[i]) begin
              live.push_back(i);
              if (board_map[i] > board_lim) total++;
              if (chan_map[i] > chan_lim) total++;
            end
          end
          // every pair of identical live entries, each pair counted once
          for (int a = 0; a < live.size(); a++) begin
            for (int b = a + 1; b < live.size(); b++) begin
              if (crate_map[live[a]] == crate_map[live[b]] &&
                  board_map[live[a]] == board_map[live[b]] &&
                  chan_map[live[a]] == chan_map[live[b]]) total++;
            end
          end
          res.problem_count = (total > 64'hFF_FFFF) ? '1 : COUNT_W'(total);
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Presents one word after a random gap and books its predicted result once taken.
  // valid is only dropped when a gap follows, so back-to-back words never see a
  // low/high pair of assignments in one step.
  task automatic send_word(input kind_t k, input logic [IDX_W-1:0] idx,
                           input logic [CRATE_W-1:0] crate, input logic [BOARD_W-1:0] board,
                           input logic [CHAN_W-1:0] chan);
    int gap;
    gap = $urandom_range(0, pace_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, chan, board, crate, idx};
    s_axis_tuser  <= k;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(map_response(k, idx, crate, board, chan));
  endtask

  // Stops the stream and waits for every booked result. Every word yields a result,
  // so once the queue is empty the block is idle and may be reconfigured.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Setup then access phase; the copy follows once the access is taken.
  task automatic write_reg(input reg_idx_t r, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(r));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_ENTRY_COUNT:   span_reg  = value[ECNT_W-1:0];
      REG_BOARD_LIMIT:   board_lim = value[BOARD_W-1:0];
      REG_CHANNEL_LIMIT: chan_lim  = value[CHAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------
  task automatic check_word(input logic [39:0] word);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result word %h arrived with nothing expected", word);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (word[0] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, word[0]);
      errors++;
    end
    if (word[1] !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, word[1]);
      errors++;
    end
    if (word[13:2] !== want.match_index) begin
      $error("match_index: expected %0d, got %0d", want.match_index, word[13:2]);
      errors++;
    end
    if (word[37:14] !== want.problem_count) begin
      $error("problem_count: expected %0d, got %0d", want.problem_count, word[37:14]);
      errors++;
    end
  endtask

  // tready is held low for a fresh random stretch after each word taken.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        check_word(m_axis_tdata);
        hold = $urandom_range(0, pace_max);
        if (hold != 0) m_axis_tready <= 1'b0;
      end else if (!m_axis_tready) begin
        if (hold <= 1) m_axis_tready <= 1'b1;
        else hold--;
      end
    end
  end

  // Watchdog: any handshake on either stream or the register port resets it.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_channel_map_reverse_lookup: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Nothing cleared yet: verify reports not loaded, a write still lands.
  task automatic test_before_clear();
    send_word(KIND_VERIFY, '0, '0, '0, '0);
    // count still 0 from reset: nothing is searched
    send_word(KIND_LOOKUP, '0, 8'hFF, 5'd31, 5'd31);
    send_word(KIND_WRITE, 12'd3, 8'h3C, 5'd7, 5'd2);
    drain();
    write_reg(REG_ENTRY_COUNT, 32'd16);
    send_word(KIND_LOOKUP, '0, 8'h3C, 5'd7, 5'd2);
    send_word(KIND_VERIFY, 12'hFFF, 8'hFF, 5'd31, 5'd31);
  endtask

  // Default limits 20/16, span 16: first-match lookup, faults, duplicates, overwrite.
  task automatic test_lookup_and_verify();
    send_word(KIND_CLEAR, 12'hFFF, 8'hFF, 5'd31, 5'd31);
    send_word(KIND_LOOKUP, '0, 8'h3C, 5'd7, 5'd2);
    send_word(KIND_WRITE, 12'd0, 8'hFF, 5'd31, 5'd31);
    send_word(KIND_WRITE, 12'd5, 8'h00, 5'd0, 5'd0);
    send_word(KIND_WRITE, 12'd9, 8'h00, 5'd0, 5'd0);
    send_word(KIND_WRITE, 12'd7, 8'hFF, 5'd31, 5'd31);
    // right on both limits: no fault
    send_word(KIND_WRITE, 12'd15, 8'hA5, 5'd20, 5'd16);
    // last table slot, outside the span for now
    send_word(KIND_WRITE, 12'hFFF, 8'h5A, 5'd21, 5'd17);
    send_word(KIND_LOOKUP, '0, 8'h00, 5'd0, 5'd0);
    send_word(KIND_LOOKUP, '0, 8'hFF, 5'd31, 5'd31);
    send_word(KIND_LOOKUP, '0, 8'h5A, 5'd21, 5'd17);
    send_word(KIND_VERIFY, '0, '0, '0, '0);
    send_word(KIND_WRITE, 12'd0, 8'h01, 5'd2, 5'd3);
    send_word(KIND_LOOKUP, '0, 8'hFF, 5'd31, 5'd31);
    send_word(KIND_VERIFY, '0, '0, '0, '0);
  endtask

  // Count past the table, the full table and one short of it; limits at both ends.
  task automatic test_span_and_limits();
    drain();
    write_reg(REG_BOARD_LIMIT, 32'd0);
    write_reg(REG_CHANNEL_LIMIT, 32'd31);
    write_reg(REG_ENTRY_COUNT, 32'd8191);
    send_word(KIND_LOOKUP, '0, 8'h5A, 5'd21, 5'd17);
    send_word(KIND_VERIFY, '0, '0, '0, '0);
    drain();
    write_reg(REG_BOARD_LIMIT, 32'd31);
    write_reg(REG_CHANNEL_LIMIT, 32'd0);
    write_reg(REG_ENTRY_COUNT, 32'd4096);
    send_word(KIND_VERIFY, '0, '0, '0, '0);
    drain();
    write_reg(REG_ENTRY_COUNT, 32'd4095);
    send_word(KIND_LOOKUP, '0, 8'h5A, 5'd21, 5'd17);
  endtask

  // One phase of random traffic. Triples come mostly from a small pool so lookups
  // hit and verify sees duplicates; the rest are fully random to toggle every bit.
  // A wide phase spreads writes over the whole table and keeps verifies rare,
  // since each one there walks thousands of pairs.
  task automatic test_random_traffic(input int n_items, input logic [ECNT_W-1:0] count,
                                     input logic [BOARD_W-1:0] b_lim,
                                     input logic [CHAN_W-1:0] c_lim,
                                     input int pace, input bit wide);
    int                 pick;
    int                 span_now;
    kind_t              k;
    logic [IDX_W-1:0]   idx;
    logic [CRATE_W-1:0] crate;
    logic [BOARD_W-1:0] board;
    logic [CHAN_W-1:0]  chan;
    drain();
    pace_max = pace;
    // junk in the unused upper bits of each register write
    write_reg(REG_ENTRY_COUNT, {19'($urandom), count});
    write_reg(REG_BOARD_LIMIT, {27'($urandom), b_lim});
    write_reg(REG_CHANNEL_LIMIT, {27'($urandom), c_lim});
    span_now = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    if (wide) send_word(KIND_CLEAR, '0, '0, '0, '0);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (wide)
        k = (pick < 2) ? KIND_CLEAR : (pick < 60) ? KIND_WRITE :
            (pick < 94) ? KIND_LOOKUP : KIND_VERIFY;
      else
        k = (pick < 6) ? KIND_CLEAR : (pick < 56) ? KIND_WRITE :
            (pick < 84) ? KIND_LOOKUP : KIND_VERIFY;
      if (wide || span_now == 0 || $urandom_range(0, 7) == 0)
        idx = IDX_W'($urandom);
      else
        idx = IDX_W'($urandom_range(0, span_now - 1));
      crate = ($urandom_range(0, 3) == 0) ? CRATE_W'($urandom) :
              ($urandom_range(0, 1) ? 8'hC3 : 8'h18);
      board = ($urandom_range(0, 3) == 0) ? BOARD_W'($urandom) :
              ($urandom_range(0, 1) ? 5'd31 : 5'd4);
      chan  = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom) :
              ($urandom_range(0, 1) ? 5'd31 : 5'd9);
      send_word(k, idx, crate, board, chan);
    end
    // close each phase with a verify over what was built
    send_word(KIND_VERIFY, IDX_W'($urandom), '0, '0, '0);
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      crate_map[i]  = '0;
      board_map[i]  = '0;
      chan_map[i]   = '0;
      entry_live[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // after reset the block sweeps its table with tready low; send_word waits it out
    test_before_clear();
    test_lookup_and_verify();
    test_span_and_limits();
    test_random_traffic(30, ECNT_W'($urandom_range(1, 48)), BOARD_W'($urandom),
                        CHAN_W'($urandom), 18, 1'b0);
    test_random_traffic(30, ECNT_W'($urandom_range(1, 16)), 5'd0, 5'd31, 0, 1'b0);
    test_random_traffic(35, ECNT_W'(4096), BOARD_W'($urandom), CHAN_W'($urandom),
                        18, 1'b1);
    test_random_traffic(10, ECNT_W'(0), 5'd31, 5'd0, 18, 1'b0);
    test_random_traffic(10, ECNT_W'($urandom_range(2, 40)), BOARD_W'($urandom),
                        CHAN_W'($urandom), 18, 1'b0);
    drain();
    // quiet tail: catches any stray result word
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_channel_map_reverse_lookup: done, clean");
    end else begin
      $display("tb_channel_map_reverse_lookup: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
